// ----- hdl/assert_macros.svh -----
// assertion macros shared by the rtl, clocked on clk with arst_n as reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define UVTB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uvtb implication failed");

// next-cycle implication
`define UVTB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uvtb next-cycle check failed");

`endif

// ----- hdl/uvtb_pkg.sv -----
`timescale 1ns / 1ps
package uvtb_pkg;
	localparam int COMP_W     = 16;
	localparam int CW         = 52;
	localparam int TOP_W      = 6;
	localparam int NORM_TOP   = 29;
	localparam int MAG_W      = 30;
	localparam int SQR_W      = 60;
	localparam int SQ_W       = 64;
	localparam int SQRT_STEPS = 31;
	localparam int LEN_W      = 31;
	localparam int FRAC_SH    = 14;
	localparam int QUO_W      = 15;
	localparam int DIV_W      = 46;

	typedef logic [2:0][CW-1:0] cvec_t;

	typedef struct packed {
		logic [47:0] n;
		logic [47:0] tpack;
		logic        degen;
	} side_t;
endpackage

// ----- hdl/uv_tangent_binormal_solver_core.sv -----
`timescale 1ns / 1ps
// tangent and binormal from a vertex normal and a uv-mapped triangle
// s_tdata carries one request: normal, three positions and three uvs
// m_tdata carries the unit tangent and binormal, m_tuser the degenerate flag
// the block is a 115-stage pipeline, and a new request can be taken every
// cycle while the output is not stalled
// the depth comes from the two normalisers, each an integer square root
// of 31 stages followed by a 15-stage divider by the length
// when the uv determinant or either cross product is zero the result
// carries zero vectors with the degenerate flag set
// all stages move together: when m_tready is low with a result waiting,
// s_tready drops and the whole pipeline holds its contents
// reset clears every stage's valid bit, so the pipeline comes up empty
`include "assert_macros.svh"
module uv_tangent_binormal_solver_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// normal_vec, pos_a, pos_b, pos_c, uv_a, uv_b, uv_c
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tangent_vec, binormal_vec
	output logic [95:0]  m_tdata,
	// degenerate
	output logic [0:0]   m_tuser
);
	localparam int CW = uvtb_pkg::CW;

	logic en;
	logic v_s9;

	assign en       = !v_s9 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s9;

	logic signed [15:0] p0 [3];
	logic signed [15:0] p1 [3];
	logic signed [15:0] p2 [3];
	logic signed [15:0] uu [3];
	logic signed [15:0] vv [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p0[i] = $signed(s_tdata[48 + 16*i +: 16]);
			p1[i] = $signed(s_tdata[96 + 16*i +: 16]);
			p2[i] = $signed(s_tdata[144 + 16*i +: 16]);
			uu[i] = $signed(s_tdata[192 + 32*i +: 16]);
			vv[i] = $signed(s_tdata[208 + 32*i +: 16]);
		end
	end

	// differences
	logic               v_s1;
	logic [47:0]        n_s1;
	logic signed [16:0] e0_s1 [3];
	logic signed [16:0] e1_s1 [3];
	logic signed [16:0] f0_s1;
	logic signed [16:0] f1_s1;
	logic signed [16:0] du_s1 [3];
	logic signed [15:0] vv_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= s_tdata[47:0];
			for (int i = 0; i < 3; i++) begin
				e0_s1[i] <= 17'(p1[i]) - 17'(p0[i]);
				e1_s1[i] <= 17'(p2[i]) - 17'(p0[i]);
				vv_s1[i] <= vv[i];
			end
			f0_s1    <= 17'(vv[0]) - 17'(vv[2]);
			f1_s1    <= 17'(vv[1]) - 17'(vv[0]);
			du_s1[0] <= 17'(uu[1]) - 17'(uu[2]);
			du_s1[1] <= 17'(uu[2]) - 17'(uu[0]);
			du_s1[2] <= 17'(uu[0]) - 17'(uu[1]);
		end
	end

	// products
	logic               v_s2;
	logic [47:0]        n_s2;
	logic signed [32:0] dp_s2 [3];
	logic signed [33:0] wp0_s2 [3];
	logic signed [33:0] wp1_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2 <= n_s1;
			for (int i = 0; i < 3; i++) begin
				dp_s2[i]  <= 33'(du_s1[i]) * 33'(vv_s1[i]);
				wp0_s2[i] <= 34'(e0_s1[i]) * 34'(f0_s1);
				wp1_s2[i] <= 34'(e1_s1[i]) * 34'(f1_s1);
			end
		end
	end

	// determinant and raw edge direction
	logic               v_s3;
	logic [47:0]        n_s3;
	logic               detz_s3;
	logic               detn_s3;
	logic signed [34:0] wr_s3 [3];
	logic signed [34:0] det_c;

	assign det_c = 35'(dp_s2[0]) + 35'(dp_s2[1]) + 35'(dp_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3    <= n_s2;
			detz_s3 <= (det_c == '0);
			detn_s3 <= det_c[34];
			for (int i = 0; i < 3; i++) begin
				wr_s3[i] <= 35'(wp0_s2[i]) + 35'(wp1_s2[i]);
			end
		end
	end

	// orient by the determinant's sign
	logic               v_s4;
	logic [47:0]        n_s4;
	logic               degen_s4;
	logic signed [34:0] w_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s4     <= n_s3;
			degen_s4 <= detz_s3;
			for (int i = 0; i < 3; i++) begin
				w_s4[i] <= detn_s3 ? -wr_s3[i] : wr_s3[i];
			end
		end
	end

	// n x w products
	logic               v_s5;
	logic [47:0]        n_s5;
	logic               degen_s5;
	logic signed [50:0] cp_s5 [6];
	logic signed [15:0] n4 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n4[i] = $signed(n_s4[16*i +: 16]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5     <= n_s4;
			degen_s5 <= degen_s4;
			cp_s5[0] <= 51'(n4[1]) * 51'(w_s4[2]);
			cp_s5[1] <= 51'(n4[2]) * 51'(w_s4[1]);
			cp_s5[2] <= 51'(n4[2]) * 51'(w_s4[0]);
			cp_s5[3] <= 51'(n4[0]) * 51'(w_s4[2]);
			cp_s5[4] <= 51'(n4[0]) * 51'(w_s4[1]);
			cp_s5[5] <= 51'(n4[1]) * 51'(w_s4[0]);
		end
	end

	// tangent cross product
	logic            v_s6;
	uvtb_pkg::cvec_t c_s6;
	uvtb_pkg::side_t sd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s6[i] <= CW'(cp_s5[2*i]) - CW'(cp_s5[2*i+1]);
			end
			sd_s6.n     <= n_s5;
			sd_s6.tpack <= '0;
			sd_s6.degen <= degen_s5;
		end
	end

	logic            ua_valid;
	logic [47:0]     ua_pack;
	logic            ua_zero;
	uvtb_pkg::side_t ua_side;

	uvtb_norm u_norm_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_vec    (c_s6),
		.in_side   (sd_s6),
		.out_valid (ua_valid),
		.out_pack  (ua_pack),
		.out_zero  (ua_zero),
		.out_side  (ua_side)
	);

	// n x t products
	logic               v_s7;
	logic [47:0]        t_s7;
	logic               degen_s7;
	logic signed [31:0] bp_s7 [6];
	logic signed [15:0] n7 [3];
	logic signed [15:0] t7 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n7[i] = $signed(ua_side.n[16*i +: 16]);
			t7[i] = $signed(ua_pack[16*i +: 16]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= ua_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s7     <= ua_pack;
			degen_s7 <= ua_side.degen || ua_zero;
			bp_s7[0] <= 32'(n7[1]) * 32'(t7[2]);
			bp_s7[1] <= 32'(n7[2]) * 32'(t7[1]);
			bp_s7[2] <= 32'(n7[2]) * 32'(t7[0]);
			bp_s7[3] <= 32'(n7[0]) * 32'(t7[2]);
			bp_s7[4] <= 32'(n7[0]) * 32'(t7[1]);
			bp_s7[5] <= 32'(n7[1]) * 32'(t7[0]);
		end
	end

	// binormal cross product
	logic            v_s8;
	uvtb_pkg::cvec_t c_s8;
	uvtb_pkg::side_t sd_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s8[i] <= CW'(bp_s7[2*i]) - CW'(bp_s7[2*i+1]);
			end
			sd_s8.n     <= '0;
			sd_s8.tpack <= t_s7;
			sd_s8.degen <= degen_s7;
		end
	end

	logic            ub_valid;
	logic [47:0]     ub_pack;
	logic            ub_zero;
	uvtb_pkg::side_t ub_side;

	uvtb_norm u_norm_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.in_vec    (c_s8),
		.in_side   (sd_s8),
		.out_valid (ub_valid),
		.out_pack  (ub_pack),
		.out_zero  (ub_zero),
		.out_side  (ub_side)
	);

	// output register
	logic degen_c;

	assign degen_c = ub_side.degen || ub_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= ub_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata[47:0]  <= degen_c ? 48'd0 : ub_side.tpack;
			m_tdata[95:48] <= degen_c ? 48'd0 : ub_pack;
			m_tuser[0]     <= degen_c;
		end
	end

	`UVTB_ASSERT_IMP(a_degen_zero, m_tvalid && m_tuser[0], m_tdata == 96'd0)
	`UVTB_ASSERT_IMP(a_tan_range, m_tvalid && !m_tuser[0], ($signed(m_tdata[15:0]) <= 16'sd16384) && ($signed(m_tdata[15:0]) >= -16'sd16384))
	`UVTB_ASSERT_NXT(a_stall_hold, !en, $stable(v_s6) && $stable(v_s8))
endmodule

// ----- hdl/uvtb_norm.sv -----
`timescale 1ns / 1ps
module uvtb_norm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  uvtb_pkg::cvec_t       in_vec,
	input  uvtb_pkg::side_t       in_side,
	output logic                  out_valid,
	output logic [47:0]           out_pack,
	output logic                  out_zero,
	output uvtb_pkg::side_t       out_side
);
	localparam int CW    = uvtb_pkg::CW;
	localparam int MW    = uvtb_pkg::MAG_W;
	localparam int SW    = uvtb_pkg::SQ_W;
	localparam int NS    = uvtb_pkg::SQRT_STEPS;
	localparam int LW    = uvtb_pkg::LEN_W;
	localparam int QW    = uvtb_pkg::QUO_W;
	localparam int DW    = uvtb_pkg::DIV_W;
	localparam int TW    = uvtb_pkg::TOP_W;
	localparam int NT    = uvtb_pkg::NORM_TOP;
	localparam int FS    = uvtb_pkg::FRAC_SH;
	localparam int CPW   = uvtb_pkg::COMP_W;

	// magnitudes and their or-word
	logic [CW-1:0]        mag_c [3];
	logic                 valid_s1;
	logic [CW-1:0]        mag_s1 [3];
	logic [2:0]           neg_s1;
	logic [CW-1:0]        orw_s1;
	uvtb_pkg::side_t      side_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_vec[i][CW-1] ? (~in_vec[i] + CW'(1)) : in_vec[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag_c[i];
				neg_s1[i] <= in_vec[i][CW-1];
			end
			orw_s1  <= mag_c[0] | mag_c[1] | mag_c[2];
			side_s1 <= in_side;
		end
	end

	// leading one of the largest magnitude
	logic [TW-1:0]        top_c;
	logic                 valid_s2;
	logic [TW-1:0]        top_s2;
	logic                 zero_s2;
	logic [CW-1:0]        mag_s2 [3];
	logic [2:0]           neg_s2;
	uvtb_pkg::side_t      side_s2;

	always_comb begin
		top_c = '0;
		for (int b = 0; b < CW; b++) begin
			if (orw_s1[b]) begin
				top_c = TW'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_s2  <= top_c;
			zero_s2 <= (orw_s1 == '0);
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
		end
	end

	// common shift so the largest has its top bit at the norm position
	logic                 valid_s3;
	logic [MW-1:0]        sh_s3 [3];
	logic                 zero_s3;
	logic [2:0]           neg_s3;
	uvtb_pkg::side_t      side_s3;
	logic [CW-1:0]        sh_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (top_s2 > TW'(NT)) begin
				sh_c[i] = mag_s2[i] >> (top_s2 - TW'(NT));
			end else begin
				sh_c[i] = mag_s2[i] << (TW'(NT) - top_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sh_s3[i] <= sh_c[i][MW-1:0];
			end
			zero_s3 <= zero_s2;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
		end
	end

	// squares
	logic                       valid_s4;
	logic [uvtb_pkg::SQR_W-1:0] sq_s4 [3];
	logic [MW-1:0]              sh_s4 [3];
	logic                       zero_s4;
	logic [2:0]                 neg_s4;
	uvtb_pkg::side_t            side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= sh_s3[i] * sh_s3[i];
			end
			sh_s4   <= sh_s3;
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
			side_s4 <= side_s3;
		end
	end

	// square root chain, one result bit per stage
	logic                 sqv_s6 [NS+1];
	logic [SW-1:0]        sqs_s6 [NS+1];
	logic [SW-1:0]        sqr_s6 [NS+1];
	logic [MW-1:0]        sqm_s6 [NS+1][3];
	logic                 sqz_s6 [NS+1];
	logic [2:0]           sqn_s6 [NS+1];
	uvtb_pkg::side_t      sqd_s6 [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s6[0] <= 1'b0;
		end else if (en) begin
			sqv_s6[0] <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqs_s6[0] <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
			sqr_s6[0] <= '0;
			sqm_s6[0] <= sh_s4;
			sqz_s6[0] <= zero_s4;
			sqn_s6[0] <= neg_s4;
			sqd_s6[0] <= side_s4;
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_sqrt
		localparam int K = NS - 1 - g;
		localparam logic [SW-1:0] BIT = SW'(1) << (2 * K);
		logic [SW-1:0] trial;

		assign trial = sqr_s6[g] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s6[g+1] <= 1'b0;
			end else if (en) begin
				sqv_s6[g+1] <= sqv_s6[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (sqs_s6[g] >= trial) begin
					sqs_s6[g+1] <= sqs_s6[g] - trial;
					sqr_s6[g+1] <= (sqr_s6[g] >> 1) + BIT;
				end else begin
					sqs_s6[g+1] <= sqs_s6[g];
					sqr_s6[g+1] <= sqr_s6[g] >> 1;
				end
				sqm_s6[g+1] <= sqm_s6[g];
				sqz_s6[g+1] <= sqz_s6[g];
				sqn_s6[g+1] <= sqn_s6[g];
				sqd_s6[g+1] <= sqd_s6[g];
			end
		end
	end

	// rounded division by the length, one quotient bit per stage
	logic                 dv_s7 [QW+1];
	logic [DW-1:0]        drem_s7 [QW+1][3];
	logic [QW-1:0]        dq_s7 [QW+1][3];
	logic [LW-1:0]        dl_s7 [QW+1];
	logic                 dz_s7 [QW+1];
	logic [2:0]           dn_s7 [QW+1];
	uvtb_pkg::side_t      dd_s7 [QW+1];
	logic [LW-1:0]        len_c;

	assign len_c = sqr_s6[NS][LW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s7[0] <= 1'b0;
		end else if (en) begin
			dv_s7[0] <= sqv_s6[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem_s7[0][i] <= (DW'(sqm_s6[NS][i]) << FS) + DW'(len_c >> 1);
				dq_s7[0][i]   <= '0;
			end
			dl_s7[0] <= len_c;
			dz_s7[0] <= sqz_s6[NS];
			dn_s7[0] <= sqn_s6[NS];
			dd_s7[0] <= sqd_s6[NS];
		end
	end

	for (genvar d = 0; d < QW; d++) begin : g_div
		localparam int J = QW - 1 - d;
		logic [DW-1:0] dsub;

		assign dsub = DW'(dl_s7[d]) << J;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s7[d+1] <= 1'b0;
			end else if (en) begin
				dv_s7[d+1] <= dv_s7[d];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (drem_s7[d][i] >= dsub) begin
						drem_s7[d+1][i]  <= drem_s7[d][i] - dsub;
						dq_s7[d+1][i]    <= dq_s7[d][i] | (QW'(1) << J);
					end else begin
						drem_s7[d+1][i]  <= drem_s7[d][i];
						dq_s7[d+1][i]    <= dq_s7[d][i];
					end
				end
				dl_s7[d+1] <= dl_s7[d];
				dz_s7[d+1] <= dz_s7[d];
				dn_s7[d+1] <= dn_s7[d];
				dd_s7[d+1] <= dd_s7[d];
			end
		end
	end

	// sign and pack
	logic [CPW-1:0] comp_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			comp_c[i] = dn_s7[QW][i] ? (~CPW'(dq_s7[QW][i]) + CPW'(1)) : CPW'(dq_s7[QW][i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_s7[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pack <= {comp_c[2], comp_c[1], comp_c[0]};
			out_zero <= dz_s7[QW];
			out_side <= dd_s7[QW];
		end
	end
endmodule

// ----- dv/uv_tangent_binormal_solver_core_tb.sv -----
`timescale 1ns / 1ps
module uv_tangent_binormal_solver_core_tb;
	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [0:0]   m_tuser;

	typedef struct packed {
		logic [47:0] tangent;
		logic [47:0] binormal;
		logic        degen;
	} basis_t;

	localparam int PIPE_DEPTH = 115;
	localparam int STALL_LIMIT = 4000;

	logic [287:0] request_q[$];
	basis_t       basis_q[$];
	int           errors = 0;
	int           n_accepted = 0;
	int           n_checked = 0;
	int           n_degen = 0;
	int           src_gap = 0;
	int           sink_gap = 0;
	int           idle_cycles = 0;
	bit           all_loaded = 0;

	uv_tangent_binormal_solver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic void queue_request(logic [287:0] r);
		request_q.insert(request_q.size(), r);
	endfunction

	function automatic longint comp16(logic [47:0] w, int k);
		logic signed [15:0] f;
		f = w[16*k +: 16];
		return longint'(f);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit make_unit(input longint c[3], output longint q[3],
			output logic [47:0] packed_w);
		longint unsigned mag[3];
		longint unsigned m;
		longint unsigned sum;
		longint unsigned len;
		longint unsigned r;
		int top;
		m = 0;
		sum = 0;
		top = 0;
		packed_w = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
			if (mag[i] > m)
				m = mag[i];
		end
		if (m == 0)
			return 0;
		while ((m >> top) > 1)
			top++;
		for (int i = 0; i < 3; i++) begin
			if (top > 29)
				mag[i] >>= (top - 29);
			else
				mag[i] <<= (29 - top);
			sum += mag[i] * mag[i];
		end
		len = root_floor(sum);
		for (int i = 0; i < 3; i++) begin
			r = (mag[i] * 16384 + len / 2) / len;
			q[i] = c[i] < 0 ? -longint'(r) : longint'(r);
			packed_w[16*i +: 16] = q[i][15:0];
		end
		return 1;
	endfunction

	function automatic void cross_prod(input longint a[3], input longint b[3],
			output longint r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic basis_t solve_request(logic [287:0] d);
		longint nv[3], p0[3], p1[3], p2[3], w[3], c[3], t[3], b[3];
		longint u[3], v[3], det;
		logic [47:0] tp, bp;
		logic signed [15:0] f;
		basis_t res;
		res = '{tangent: '0, binormal: '0, degen: 1'b1};
		for (int i = 0; i < 3; i++) begin
			nv[i] = comp16(d[47:0], i);
			p0[i] = comp16(d[95:48], i);
			p1[i] = comp16(d[143:96], i);
			p2[i] = comp16(d[191:144], i);
			f = d[192 + 32*i +: 16];
			u[i] = f;
			f = d[208 + 32*i +: 16];
			v[i] = f;
		end
		det = u[1]*v[0] - u[2]*v[0] - u[0]*v[1] + u[2]*v[1] + u[0]*v[2] - u[1]*v[2];
		if (det == 0)
			return res;
		for (int i = 0; i < 3; i++) begin
			w[i] = (p1[i] - p0[i]) * (v[0] - v[2]) + (p2[i] - p0[i]) * (v[1] - v[0]);
			if (det < 0)
				w[i] = -w[i];
		end
		cross_prod(nv, w, c);
		if (!make_unit(c, t, tp))
			return res;
		cross_prod(nv, t, c);
		if (!make_unit(c, b, bp))
			return res;
		res = '{tangent: tp, binormal: bp, degen: 1'b0};
		return res;
	endfunction

	function automatic logic [15:0] rnd_comp();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 1200)) - 600);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] rnd_vec();
		return {rnd_comp(), rnd_comp(), rnd_comp()};
	endfunction

	function automatic logic [47:0] rnd_unit();
		case ($urandom_range(0, 3))
			0: return {16'd0, 16'd0, 16'd16384};
			1: return {16'd16384, 16'd0, 16'd0};
			2: return {16'(-16384), 16'd0, 16'd0};
			default: return {16'($urandom_range(0, 32767) - 16384),
				16'($urandom_range(0, 32767) - 16384),
				16'($urandom_range(0, 32767) - 16384)};
		endcase
	endfunction

	function automatic logic [287:0] pack_request(logic [47:0] nv, logic [47:0] pa,
			logic [47:0] pb, logic [47:0] pc, logic [31:0] ua, logic [31:0] ub,
			logic [31:0] uc);
		return {uc, ub, ua, pc, pb, pa, nv};
	endfunction

	initial begin
		logic [47:0] nv, pa, pb, pc;
		logic [31:0] ua, ub, uc;
		// good triangle, unit normal along x
		queue_request(pack_request({16'd0, 16'd0, 16'd16384},
			48'h0, {16'd0, 16'd0, 16'd256}, {16'd0, 16'd256, 16'd0},
			32'h0, {16'd0, 16'd16384}, {16'd16384, 16'd0}));
		// zero determinant: all uvs equal
		queue_request(pack_request({16'd0, 16'd0, 16'd16384},
			48'h0, {16'd0, 16'd0, 16'd256}, {16'd0, 16'd256, 16'd0},
			32'h12345678, 32'h12345678, 32'h12345678));
		// zero normal
		queue_request(pack_request(48'h0,
			48'h0, {16'd0, 16'd0, 16'd256}, {16'd0, 16'd256, 16'd0},
			32'h0, {16'd0, 16'd16384}, {16'd16384, 16'd0}));
		// normal perpendicular to the edge direction
		queue_request(pack_request({16'd0, 16'd0, 16'd16384},
			48'h0, {16'd256, 16'd0, 16'd0}, {16'd256, 16'd0, 16'd0},
			32'h0, {16'd0, 16'd16384}, {16'd16384, 16'd0}));
		// positive determinant
		queue_request(pack_request({16'd0, 16'd16384, 16'd0},
			48'h0, {16'd0, 16'd0, 16'd256}, {16'd256, 16'd0, 16'd0},
			32'h0, {16'd16384, 16'd0}, {16'd0, 16'd16384}));
		// extremes of every field
		queue_request({288{1'b1}});
		queue_request({36{8'h80}});
		queue_request({144{2'b01}});
		queue_request({144{2'b10}});
		queue_request(pack_request({3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}},
			48'h0, {16'h8000, 16'h7fff}, {16'h7fff, 16'h8000}, 32'h0));
		queue_request(pack_request({3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}},
			{16'h7fff, 16'h8000, 16'h7fff}, 32'h7fff8000, 32'h80007fff, 32'h7fff7fff));
		queue_request(pack_request({16'h0001, 16'h0, 16'h0}, 48'h0, 48'h1,
			{16'h0, 16'h1, 16'h0}, 32'h0, 32'h00010000, 32'h00000001));
		for (int k = 0; k < 650; k++) begin
			if ($urandom_range(0, 9) < 7)
				nv = rnd_unit();
			else
				nv = rnd_vec();
			pa = rnd_vec();
			pb = rnd_vec();
			pc = rnd_vec();
			ua = {rnd_comp(), rnd_comp()};
			ub = {rnd_comp(), rnd_comp()};
			uc = {rnd_comp(), rnd_comp()};
			case ($urandom_range(0, 9))
				0: ub = ua;
				1: begin ub = ua; uc = ua; end
				2: pc = pb;
				3: nv = 48'h0;
				default: ;
			endcase
			queue_request(pack_request(nv, pa, pb, pc, ua, ub, uc));
		end
		all_loaded = 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				basis_q.insert(basis_q.size(), solve_request(s_tdata));
				n_accepted <= n_accepted + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (request_q.size() > 0) begin
					s_tdata <= request_q.pop_front();
					s_tvalid <= 1'b1;
					src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		basis_t seen, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = '{tangent: m_tdata[47:0], binormal: m_tdata[95:48], degen: m_tuser[0]};
				if (basis_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, seen);
					errors++;
				end else begin
					want = basis_q.pop_front();
					n_checked++;
					if (want.degen)
						n_degen++;
					if (seen.tangent !== want.tangent) begin
						$display("%0t: tangent expected %h actual %h", $time,
							want.tangent, seen.tangent);
						errors++;
					end
					if (seen.binormal !== want.binormal) begin
						$display("%0t: binormal expected %h actual %h", $time,
							want.binormal, seen.binormal);
						errors++;
					end
					if (seen.degen !== want.degen) begin
						$display("%0t: degenerate expected %b actual %b", $time,
							want.degen, seen.degen);
						errors++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (!all_loaded)
			@(posedge clk);
		while (request_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (basis_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH * 2) @(posedge clk);
		$display("sent %0d requests, checked %0d results (%0d degenerate)",
			n_accepted, n_checked, n_degen);
		$display("random normals, positions and uvs with both sides stalling");
		if (errors == 0 && basis_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
